/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checker file wsnr_checker.sv.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, quiet while reset is asserted
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("implication check failed");

// next-cycle implication, quiet while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

/* hw/rtl/wsnr_pkg.sv */
// ----------------------------------------------------------------------------
// wsnr_pkg
// Types, codes and defaults shared by the weighted sampler modules.
// ----------------------------------------------------------------------------
package wsnr_pkg;

	localparam int MAX_ITEMS_DEF   = 64;
	localparam int WEIGHT_BITS_DEF = 16;
	localparam int RAND_BITS_DEF   = 16;

	localparam int ID_W = 7;

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_LOAD  = 2'd1,
		OP_DRAW  = 2'd2,
		OP_NOP   = 2'd3
	} op_t;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic [1:0]  operation;
		logic [15:0] weight;
		logic [15:0] uniform_fraction;
	} in_word_t;

	typedef struct packed {
		logic [ID_W-1:0] chosen_identity;
		logic [1:0]      status;
		logic [ID_W-1:0] remaining;
	} out_word_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic clear;
		logic res_full;
		logic res_empty;
		logic ins_start;
		logic ins_step;
		logic put;
		logic mul_start;
		logic mul_step;
		logic tgt;
		logic walk_step;
		logic shift_step;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic full;
		logic empty;
		logic ins_hit;
		logic a_zero;
		logic mul_last;
		logic walk_hit;
		logic at_last;
		logic shift_done;
	} stat_t;

endpackage

/* hw/rtl/wsnr_ctrl.sv */
// ----------------------------------------------------------------------------
// wsnr_ctrl
// Sequencer for clear, load (ordered insert) and draw (scale, walk, compact).
// ----------------------------------------------------------------------------
module wsnr_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  wsnr_pkg::op_t  op,
	input  wsnr_pkg::stat_t st,
	output wsnr_pkg::cmd_t cmd,
	output logic           busy,
	output logic           done
);
	import wsnr_pkg::*;

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_INS   = 8'b0000_0010,
		S_PUT   = 8'b0000_0100,
		S_MUL   = 8'b0000_1000,
		S_TGT   = 8'b0001_0000,
		S_WALK  = 8'b0010_0000,
		S_SHIFT = 8'b0100_0000,
		S_RESP  = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					state_d     = S_RESP;
					case (op)
						OP_CLEAR: begin
							cmd.clear = 1'b1;
						end
						OP_LOAD: begin
							if (st.full) begin
								cmd.res_full = 1'b1;
							end else if (st.empty) begin
								state_d = S_PUT;
							end else begin
								cmd.ins_start = 1'b1;
								state_d       = S_INS;
							end
						end
						OP_DRAW: begin
							if (st.empty) begin
								cmd.res_empty = 1'b1;
							end else begin
								cmd.mul_start = 1'b1;
								state_d       = S_MUL;
							end
						end
						default: begin
							state_d = S_RESP;
						end
					endcase
				end
			end
			S_INS: begin
				cmd.ins_step = 1'b1;
				if (st.ins_hit) begin
					state_d = S_RESP;
				end else if (st.a_zero) begin
					state_d = S_PUT;
				end
			end
			S_PUT: begin
				cmd.put = 1'b1;
				state_d = S_RESP;
			end
			S_MUL: begin
				cmd.mul_step = 1'b1;
				if (st.mul_last) begin
					state_d = S_TGT;
				end
			end
			S_TGT: begin
				cmd.tgt = 1'b1;
				state_d = S_WALK;
			end
			S_WALK: begin
				cmd.walk_step = 1'b1;
				if (st.walk_hit) begin
					state_d = st.at_last ? S_RESP : S_SHIFT;
				end
			end
			S_SHIFT: begin
				cmd.shift_step = 1'b1;
				if (st.shift_done) begin
					state_d = S_RESP;
				end
			end
			S_RESP: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_RESP);

endmodule

/* hw/rtl/wsnr_dp.sv */
// ----------------------------------------------------------------------------
// wsnr_dp
// Sorted item table in a single-port-read memory, mass bookkeeping,
// shift-add scaler and running-sum walk.
// ----------------------------------------------------------------------------
module wsnr_dp #(
	parameter int MAX_ITEMS   = wsnr_pkg::MAX_ITEMS_DEF,
	parameter int WEIGHT_BITS = wsnr_pkg::WEIGHT_BITS_DEF,
	parameter int RAND_BITS   = wsnr_pkg::RAND_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  wsnr_pkg::in_word_t  item,
	input  wsnr_pkg::cmd_t      cmd,
	output wsnr_pkg::stat_t     st,
	output wsnr_pkg::out_word_t result
);
	import wsnr_pkg::*;

	localparam int AW     = $clog2(MAX_ITEMS);
	localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
	localparam int MASS_W = WEIGHT_BITS + AW;
	localparam int PROD_W = MASS_W + RAND_BITS;
	localparam int MCW    = $clog2(RAND_BITS);

	typedef struct packed {
		logic [ID_W-1:0]        id;
		logic [WEIGHT_BITS-1:0] w;
	} entry_t;

	entry_t mem [MAX_ITEMS];
	entry_t rdata_q, wr_data, new_ent;
	logic   wr_en;
	logic [AW-1:0] wr_addr, rd_addr;

	logic [CNT_W-1:0]       count_q;
	logic [MASS_W-1:0]      total_q;
	logic [ID_W-1:0]        nid_q, nid_inc;
	logic [WEIGHT_BITS-1:0] w_q;
	logic [AW-1:0]          a_q, last_q, a_inc, a_dec, a_inc2;
	logic [MASS_W-1:0]      mass_q, mass_n, target_q;
	logic [PROD_W-1:0]      prod_q, mcand_q;
	logic [RAND_BITS-1:0]   mult_q;
	logic [MCW-1:0]         mcnt_q;
	logic [ID_W-1:0]        chosen_q;
	logic [1:0]             status_q;
	logic ins_hit, at_last, walk_hit, commit;

	assign ins_hit  = (rdata_q.w >= w_q);
	assign mass_n   = mass_q + MASS_W'(rdata_q.w);
	assign at_last  = (a_q == last_q);
	assign walk_hit = at_last || (target_q <= mass_n);
	assign a_inc    = a_q + 1'b1;
	assign a_dec    = a_q - 1'b1;
	assign a_inc2   = a_q + AW'(2);
	assign new_ent  = '{id: nid_q, w: w_q};
	assign commit   = (cmd.ins_step && ins_hit) || cmd.put;
	assign nid_inc  = nid_q + 1'b1;

	// read and write addressing
	always_comb begin
		rd_addr = a_inc;
		wr_en   = 1'b0;
		wr_addr = a_q;
		wr_data = rdata_q;
		if (cmd.ins_start) begin
			rd_addr = AW'(count_q - 1'b1);
		end
		if (cmd.ins_step) begin
			rd_addr = a_dec;
			wr_en   = 1'b1;
			wr_addr = a_inc;
			wr_data = ins_hit ? new_ent : rdata_q;
		end
		if (cmd.put) begin
			wr_en   = 1'b1;
			wr_addr = '0;
			wr_data = new_ent;
		end
		if (cmd.tgt) begin
			rd_addr = '0;
		end
		if (cmd.shift_step) begin
			rd_addr = a_inc2;
			wr_en   = 1'b1;
			wr_addr = a_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			total_q <= '0;
			nid_q   <= ID_W'(1);
		end else if (cmd.clear) begin
			count_q <= '0;
			total_q <= '0;
			nid_q   <= ID_W'(1);
		end else if (commit) begin
			count_q <= count_q + 1'b1;
			total_q <= total_q + MASS_W'(w_q);
			// identity wraps past its top back to one, never zero
			nid_q   <= (nid_inc == '0) ? ID_W'(1) : nid_inc;
		end else if (cmd.walk_step && walk_hit) begin
			count_q <= count_q - 1'b1;
			total_q <= total_q - MASS_W'(rdata_q.w);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			w_q      <= WEIGHT_BITS'(item.weight);
			last_q   <= AW'(count_q - 1'b1);
			chosen_q <= '0;
			if (cmd.res_full) begin
				status_q <= ST_FULL;
			end else if (cmd.res_empty) begin
				status_q <= ST_EMPTY;
			end else begin
				status_q <= ST_OK;
			end
		end
		if (cmd.ins_start) begin
			a_q <= AW'(count_q - 1'b1);
		end
		if (cmd.ins_step && !ins_hit) begin
			a_q <= a_dec;
		end
		if (cmd.mul_start) begin
			prod_q  <= '0;
			mcand_q <= PROD_W'(total_q);
			mult_q  <= RAND_BITS'(item.uniform_fraction);
			mcnt_q  <= '0;
		end
		if (cmd.mul_step) begin
			if (mult_q[0]) begin
				prod_q <= prod_q + mcand_q;
			end
			mcand_q <= mcand_q << 1;
			mult_q  <= mult_q >> 1;
			mcnt_q  <= mcnt_q + 1'b1;
		end
		if (cmd.tgt) begin
			// round the scaled mass up so that the compare is exact
			target_q <= prod_q[PROD_W-1:RAND_BITS] + MASS_W'(|prod_q[RAND_BITS-1:0]);
			a_q      <= '0;
			mass_q   <= '0;
		end
		if (cmd.walk_step) begin
			if (walk_hit) begin
				chosen_q <= rdata_q.id;
			end else begin
				mass_q <= mass_n;
				a_q    <= a_inc;
			end
		end
		if (cmd.shift_step) begin
			a_q <= a_inc;
		end
	end

	assign st.full       = (count_q == CNT_W'(MAX_ITEMS));
	assign st.empty      = (count_q == '0);
	assign st.ins_hit    = ins_hit;
	assign st.a_zero     = (a_q == '0);
	assign st.mul_last   = (mcnt_q == MCW'(RAND_BITS - 1));
	assign st.walk_hit   = walk_hit;
	assign st.at_last    = at_last;
	assign st.shift_done = (a_inc == last_q);

	assign result.chosen_identity = chosen_q;
	assign result.status          = status_q;
	assign result.remaining       = ID_W'(count_q);

endmodule

/* hw/rtl/weighted_sample_no_replace_top.sv */
// ----------------------------------------------------------------------------
// weighted_sample_no_replace_top
// Weighted sampling without replacement over a table kept in descending
// weight order.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low; its result appears for
// one cycle with done and must be captured then, as there is no back-pressure.
// Clear, unused codes, a load into a full table and a draw from an empty one
// go straight to the response; a load into an empty table writes the head,
// other loads step from the tail to the insert position, and a draw runs the
// scaler, the walk and, unless the last entry is drawn, the compaction. Load
// and draw time is set by the table memory, read one entry per cycle in the
// ordered insert, the running-sum walk and the compaction and written in the
// insert and compaction, and by the shift-add scaler, which takes one bit of
// the fraction per cycle. The table needs no clearing pass after reset.
// ----------------------------------------------------------------------------
module weighted_sample_no_replace_top #(
	parameter int MAX_ITEMS   = wsnr_pkg::MAX_ITEMS_DEF,
	parameter int WEIGHT_BITS = wsnr_pkg::WEIGHT_BITS_DEF,
	parameter int RAND_BITS   = wsnr_pkg::RAND_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  wsnr_pkg::in_word_t  item,
	output logic                done,
	output wsnr_pkg::out_word_t result
);
	import wsnr_pkg::*;

	cmd_t  cmd;
	stat_t st;

	wsnr_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.op     (op_t'(item.operation)),
		.st     (st),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	wsnr_dp #(
		.MAX_ITEMS   (MAX_ITEMS),
		.WEIGHT_BITS (WEIGHT_BITS),
		.RAND_BITS   (RAND_BITS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.st     (st),
		.result (result)
	);

endmodule

/* hw/rtl/wsnr_checker.sv */
// ----------------------------------------------------------------------------
// wsnr_checker
// Port-level checks on the sampler's command handshake and result words.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wsnr_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                start,
	input logic                busy,
	input logic                done,
	input wsnr_pkg::out_word_t result
);
	import wsnr_pkg::*;

	logic accept;
	assign accept = start && !busy;

	`ASSERT_NEXT(a_accept_busy, clk, arst_n, accept, busy)
	`ASSERT_NEXT(a_done_releases, clk, arst_n, done, !busy)
	`ASSERT_IMPLIES(a_err_no_id, clk, arst_n, done && (result.status != ST_OK), result.chosen_identity == '0)
	`ASSERT_IMPLIES(a_empty_count, clk, arst_n, done && (result.status == ST_EMPTY), result.remaining == '0)

endmodule

bind weighted_sample_no_replace_top wsnr_checker u_wsnr_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);

/* dv/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives clear, load, draw and unused command words into the weighted
// sampler and checks every result word against its typed plan value or an
// in-bench table model: a short directed table first, then fill/drain
// passes and random episodes, under three sender idle profiles.
// ----------------------------------------------------------------------------
module testbench;
	import wsnr_pkg::*;

	localparam int DEPTH       = MAX_ITEMS_DEF;
	localparam int QUIET_LIMIT = 4000;
	localparam int WORD_GOAL   = 700;

	typedef struct {
		in_word_t  word;
		bit        typed;
		out_word_t want;
	} plan_row_t;

	logic      clk;
	logic      arst_n;
	logic      start;
	logic      busy;
	in_word_t  item;
	logic      done;
	out_word_t result;

	// table model
	logic [15:0] tbl_weight [DEPTH];
	logic [6:0]  tbl_id [DEPTH];
	int          tbl_count = 0;
	logic [21:0] tbl_mass = '0;
	logic [6:0]  next_id = 7'd1;

	out_word_t pending_results [$];
	plan_row_t plan [$];
	int        fail_count = 0;
	int        words_sent = 0;
	int        idle_pct = 7;
	int        quiet_cycles = 0;

	weighted_sample_no_replace_top DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.done   (done),
		.result (result)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	task automatic report_mismatch(input string what, input logic [15:0] got,
		input logic [15:0] want);
		$display("%0t: mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
		fail_count++;
	endtask

	// apply one command word to the table model and return its result word
	function automatic out_word_t sample_step(input in_word_t w);
		out_word_t   res;
		logic [37:0] prod;
		logic [22:0] target;
		logic [22:0] run;
		int          pos;
		int          last;
		res = '0;
		res.status = ST_OK;
		case (op_t'(w.operation))
			OP_CLEAR: begin
				tbl_count = 0;
				tbl_mass = '0;
				next_id = 7'd1;
			end
			OP_LOAD: begin
				if (tbl_count >= DEPTH) begin
					res.status = ST_FULL;
				end else begin
					pos = 0;
					while (pos < tbl_count && tbl_weight[pos] >= w.weight)
						pos++;
					for (int k = tbl_count; k > pos; k--) begin
						tbl_weight[k] = tbl_weight[k-1];
						tbl_id[k] = tbl_id[k-1];
					end
					tbl_weight[pos] = w.weight;
					tbl_id[pos] = next_id;
					tbl_count++;
					tbl_mass = tbl_mass + w.weight;
					// identities skip zero on wrap
					next_id = next_id + 7'd1;
					if (next_id == 7'd0)
						next_id = 7'd1;
				end
			end
			OP_DRAW: begin
				if (tbl_count == 0) begin
					res.status = ST_EMPTY;
				end else begin
					prod = tbl_mass * w.uniform_fraction;
					target = prod[37:16] + (prod[15:0] != 16'd0);
					last = tbl_count - 1;
					pos = 0;
					run = tbl_weight[0];
					// fall back to the last entry if the sum never catches up
					while (pos < last && target > run) begin
						pos++;
						run = run + tbl_weight[pos];
					end
					res.chosen_identity = tbl_id[pos];
					tbl_mass = tbl_mass - tbl_weight[pos];
					for (int k = pos; k < last; k++) begin
						tbl_weight[k] = tbl_weight[k+1];
						tbl_id[k] = tbl_id[k+1];
					end
					tbl_count = last;
				end
			end
			default: ;
		endcase
		res.remaining = 7'(tbl_count);
		return res;
	endfunction

	// present one word, hold it until taken, then log its expected result
	task automatic push_word(input in_word_t w, input bit typed, input out_word_t want);
		out_word_t predicted;
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		start <= 1'b1;
		item <= w;
		do @(posedge clk); while (busy);
		predicted = sample_step(w);
		pending_results.push_back(typed ? want : predicted);
		words_sent++;
		if (words_sent == WORD_GOAL / 3)
			idle_pct = 48;
		else if (words_sent == 2 * WORD_GOAL / 3)
			idle_pct = 0;
	endtask

	function automatic logic [15:0] pick_weight();
		case ($urandom_range(7))
			0, 1: return 16'($urandom_range(3));
			2: return $urandom_range(1) ? 16'hFFFF : 16'h0000;
			default: return 16'($urandom_range(16'hFFFF));
		endcase
	endfunction

	function automatic logic [15:0] pick_fraction();
		case ($urandom_range(7))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'($urandom_range(255));
			default: return 16'($urandom_range(16'hFFFF));
		endcase
	endfunction

	function automatic in_word_t random_word(input op_t op);
		in_word_t w;
		w.operation = op;
		w.weight = pick_weight();
		w.uniform_fraction = pick_fraction();
		return w;
	endfunction

	task automatic fill_and_drain();
		while (tbl_count < DEPTH)
			push_word(random_word(OP_LOAD), 1'b0, '0);
		repeat ($urandom_range(1, 3)) push_word(random_word(OP_LOAD), 1'b0, '0);
		while (tbl_count > 0)
			push_word(random_word(OP_DRAW), 1'b0, '0);
		repeat ($urandom_range(1, 2)) push_word(random_word(OP_DRAW), 1'b0, '0);
	endtask

	task automatic mixed_episode();
		int len;
		int pick;
		len = $urandom_range(8, 40);
		if ($urandom_range(1))
			push_word(random_word(OP_CLEAR), 1'b0, '0);
		repeat (len) begin
			pick = $urandom_range(99);
			if (pick < 55)
				push_word(random_word(OP_LOAD), 1'b0, '0);
			else if (pick < 92)
				push_word(random_word(OP_DRAW), 1'b0, '0);
			else if (pick < 96)
				push_word(random_word(OP_NOP), 1'b0, '0);
			else
				push_word(random_word(OP_CLEAR), 1'b0, '0);
		end
	endtask

	// result check
	always @(posedge clk) begin
		out_word_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result with nothing pending", 16'(result), 16'h0);
			end else begin
				want = pending_results.pop_front();
				if (result.chosen_identity !== want.chosen_identity)
					report_mismatch("chosen_identity", 16'(result.chosen_identity),
						16'(want.chosen_identity));
				if (result.status !== want.status)
					report_mismatch("status", 16'(result.status), 16'(want.status));
				if (result.remaining !== want.remaining)
					report_mismatch("remaining", 16'(result.remaining), 16'(want.remaining));
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((start && !busy) || done) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("testbench: done, errors");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		start <= 1'b0;
		item <= '0;
		arst_n <= 1'b0;
		plan = '{
			'{'{OP_DRAW,  16'h0000, 16'h0000}, 1'b1, '{7'd0, ST_EMPTY, 7'd0}},
			'{'{OP_NOP,   16'hFFFF, 16'hFFFF}, 1'b1, '{7'd0, ST_OK,    7'd0}},
			'{'{OP_LOAD,  16'hFFFF, 16'hFFFF}, 1'b1, '{7'd0, ST_OK,    7'd1}},
			'{'{OP_LOAD,  16'h0000, 16'h0000}, 1'b1, '{7'd0, ST_OK,    7'd2}},
			'{'{OP_LOAD,  16'hFFFF, 16'h0000}, 1'b0, '0},
			'{'{OP_LOAD,  16'h8000, 16'h5A5A}, 1'b0, '0},
			'{'{OP_DRAW,  16'hFFFF, 16'h0000}, 1'b1, '{7'd1, ST_OK,    7'd3}},
			'{'{OP_DRAW,  16'hFFFF, 16'hFFFF}, 1'b0, '0},
			'{'{OP_DRAW,  16'h0000, 16'h8000}, 1'b0, '0},
			'{'{OP_DRAW,  16'hA5A5, 16'h0001}, 1'b0, '0},
			'{'{OP_DRAW,  16'h0000, 16'hFFFF}, 1'b1, '{7'd0, ST_EMPTY, 7'd0}},
			'{'{OP_LOAD,  16'h0000, 16'hFFFF}, 1'b0, '0},
			'{'{OP_LOAD,  16'h0000, 16'h0000}, 1'b0, '0},
			'{'{OP_DRAW,  16'h0000, 16'h1234}, 1'b0, '0},
			'{'{OP_CLEAR, 16'hFFFF, 16'hFFFF}, 1'b1, '{7'd0, ST_OK,    7'd0}},
			'{'{OP_LOAD,  16'h0001, 16'h0000}, 1'b1, '{7'd0, ST_OK,    7'd1}},
			'{'{OP_LOAD,  16'h0001, 16'h0000}, 1'b0, '0},
			'{'{OP_DRAW,  16'h0000, 16'hFFFF}, 1'b0, '0},
			'{'{OP_NOP,   16'h0000, 16'h0000}, 1'b0, '0},
			'{'{OP_CLEAR, 16'h0000, 16'h0000}, 1'b1, '{7'd0, ST_OK,    7'd0}}
		};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (plan[i])
			push_word(plan[i].word, plan[i].typed, plan[i].want);
		// two full passes without a clear carry identities past the wrap
		fill_and_drain();
		fill_and_drain();
		while (words_sent < WORD_GOAL) begin
			if ($urandom_range(7) == 0)
				fill_and_drain();
			else
				mixed_episode();
		end
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (fail_count == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule
